@@ rtl/core/mco_pkg.sv @@
// ----------------------------------------------------------------------------
// mco_pkg
// Shared widths, defaults and the sequencer state type of the matrix chain
// order block.
// ----------------------------------------------------------------------------
package mco_pkg;

  localparam int unsigned DefMaxMatrices = 16;
  localparam int unsigned DefDimBits     = 12;

  localparam int unsigned DimPortW = 12;  // width of the dimension port
  localparam int unsigned CostW    = 48;  // width of every cost value
  localparam int unsigned SpanW    = 5;   // width of the span and split ports

  localparam logic [CostW-1:0] CostMax = '1;

  localparam logic KindCost  = 1'b0;
  localparam logic KindSplit = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_SPAN0,
    S_SPAN1,
    S_SPAN2,
    S_K0,
    S_K1,
    S_K2,
    S_K3,
    S_K4,
    S_WR,
    S_TOT0,
    S_TOT1,
    S_POP,
    S_EMIT
  } mco_state_e;

endpackage

@@ rtl/core/mco_ram.sv @@
// ----------------------------------------------------------------------------
// mco_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module mco_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/matrix_chain_order_dp.sv @@
// ----------------------------------------------------------------------------
// matrix_chain_order_dp
// Optimal matrix chain parenthesisation by bottom-up dynamic programming,
// with the cost and split tables held in synchronous RAM.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+---------------------------------------
//  command  | start_i, accepted when     | dimension_i, last_dimension_i
//           | busy_o is low              |
//  result   | result_valid_o, one-cycle  | result_kind_o, total_cost_o,
//           | strobe, always taken       | span_start_o, span_end_o, split_at_o,
//           |                            | overflow_o, last_result_o
//
// A dimension without the last flag leaves busy_o low, and the next transaction
// may follow at once. The closing transaction raises busy_o while the tables
// are filled: first the unit-span costs are cleared, then every span of t
// matrices is worked split by split, paced by the single read port of the cost RAM
// (two cost reads per candidate split) and the two-stage multiply. The
// traceback then reads the total cost and then each split from the table.
// Reset clears the sequencer, the dimension count and the overflow flag; the
// RAM contents need no reset, since only entries written for the present
// chain are ever read. The receiver cannot stall, so each result transaction
// is shown for exactly one cycle.
//
module matrix_chain_order_dp #(
  parameter int unsigned MAX_MATRICES = mco_pkg::DefMaxMatrices,
  parameter int unsigned DIM_BITS     = mco_pkg::DefDimBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [mco_pkg::DimPortW-1:0] dimension_i,
  input  logic                         last_dimension_i,
  output logic                         result_valid_o,
  output logic                         result_kind_o,
  output logic [mco_pkg::CostW-1:0]    total_cost_o,
  output logic [mco_pkg::SpanW-1:0]    span_start_o,
  output logic [mco_pkg::SpanW-1:0]    span_end_o,
  output logic [mco_pkg::SpanW-1:0]    split_at_o,
  output logic                         overflow_o,
  output logic                         last_result_o
);

  import mco_pkg::*;

  localparam int unsigned NDims = MAX_MATRICES + 1;
  localparam int unsigned IdxW  = $clog2(NDims);          // a dimension index
  localparam int unsigned CntW  = $clog2(NDims + 1);      // a count up to NDims
  localparam int unsigned TabD  = NDims * NDims;
  localparam int unsigned TabAW = $clog2(TabD);
  localparam int unsigned ProdW = 2 * DIM_BITS;

  typedef struct packed {
    logic [IdxW-1:0] lo;
    logic [IdxW-1:0] hi;
  } span_t;

  function automatic logic [TabAW-1:0] tab_addr(logic [IdxW-1:0] r, logic [IdxW-1:0] c);
    return TabAW'(int'(r) * NDims + int'(c));
  endfunction

  mco_state_e state_q, state_d;

  logic [CntW-1:0]     cnt_q, cnt_d;        // dimensions stored
  logic                ovf_q, ovf_d;
  logic [IdxW-1:0]     n_q, n_d;            // matrices in the chain
  logic [CntW-1:0]     t_q, t_d;            // span length in matrices
  logic [IdxW-1:0]     a_q, a_d;
  logic [IdxW-1:0]     b_q, b_d;
  logic [IdxW-1:0]     k_q, k_d;
  logic [DIM_BITS-1:0] pa_q, pa_d, pb_q, pb_d, pk_q, pk_d;
  logic [CostW-1:0]    c1_q, c1_d, sum_q, sum_d;
  logic [ProdW-1:0]    p1_q, p1_d;
  logic [CostW-1:0]    p2_q, p2_d;
  logic [CostW-1:0]    best_q, best_d;
  logic [IdxW-1:0]     bestk_q, bestk_d;
  logic [CntW-1:0]     sp_q, sp_d;
  span_t               stack_q [NDims];
  span_t               stack_d [NDims];

  // Result register.
  logic             rv_q, rv_d;
  logic             rkind_q, rkind_d;
  logic [CostW-1:0] rcost_q, rcost_d;
  logic [IdxW-1:0]  rs_q, rs_d, re_q, re_d, rk_q, rk_d;
  logic             rlast_q, rlast_d;
  logic             rovf_q, rovf_d;

  // RAM ports.
  logic                  dim_we;
  logic [IdxW-1:0]       dim_waddr, dim_raddr;
  logic [DIM_BITS-1:0]   dim_wdata, dim_rdata;
  logic                  cost_we;
  logic [TabAW-1:0]      cost_waddr, cost_raddr;
  logic [CostW-1:0]      cost_wdata, cost_rdata;
  logic [CostW+IdxW-1:0] tab_rdata;
  logic [IdxW-1:0]       split_rdata;

  logic [CostW:0]  wide_sum;
  logic [CostW-1:0] cand;
  span_t           top;
  logic            push_r, push_l;
  logic [CntW-1:0] sp_pop;

  mco_ram #(.Width(DIM_BITS), .Depth(NDims)) u_dims (
    .clk_i, .we_i(dim_we), .waddr_i(dim_waddr), .wdata_i(dim_wdata),
    .raddr_i(dim_raddr), .rdata_o(dim_rdata)
  );

  // Each table word holds the cost of a span with its best split above it.
  mco_ram #(.Width(CostW + IdxW), .Depth(TabD)) u_cost (
    .clk_i, .we_i(cost_we), .waddr_i(cost_waddr), .wdata_i({bestk_q, cost_wdata}),
    .raddr_i(cost_raddr), .rdata_o(tab_rdata)
  );

  assign cost_rdata  = tab_rdata[CostW-1:0];
  assign split_rdata = tab_rdata[CostW +: IdxW];

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;     ovf_d = ovf_q;    n_d = n_q;     t_d = t_q;
    a_d = a_q;         b_d = b_q;        k_d = k_q;
    pa_d = pa_q;       pb_d = pb_q;      pk_d = pk_q;
    c1_d = c1_q;       sum_d = sum_q;    p1_d = p1_q;   p2_d = p2_q;
    best_d = best_q;   bestk_d = bestk_q;
    sp_d = sp_q;       stack_d = stack_q;
    rv_d = 1'b0;       rkind_d = rkind_q; rcost_d = rcost_q;
    rs_d = rs_q;       re_d = re_q;      rk_d = rk_q;
    rlast_d = rlast_q; rovf_d = rovf_q;

    dim_we = 1'b0;
    dim_waddr = cnt_q[IdxW-1:0];
    dim_wdata = DIM_BITS'(dimension_i);
    dim_raddr = a_q;
    cost_we = 1'b0;
    cost_waddr = tab_addr(a_q, b_q);
    cost_wdata = best_q;
    cost_raddr = tab_addr(a_q, k_q);

    wide_sum = '0;
    cand = '0;
    top = stack_q[0];
    push_r = 1'b0;
    push_l = 1'b0;
    sp_pop = sp_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (cnt_q < CntW'(NDims)) begin
            dim_we = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (last_dimension_i) begin
            // cnt_d is at least one here, as the store is never empty when full.
            n_d = IdxW'(cnt_d - 1'b1);
            a_d = '0;
            state_d = (cnt_d > CntW'(1)) ? S_INIT : S_TOT0;
          end
        end
      end
      S_INIT: begin
        // Unit spans cost nothing.
        cost_we = 1'b1;
        cost_waddr = tab_addr(a_q, a_q + 1'b1);
        cost_wdata = '0;
        if (a_q + 1'b1 == n_q) begin
          a_d = '0;
          t_d = CntW'(2);
          state_d = (n_q >= IdxW'(2)) ? S_SPAN0 : S_TOT0;
        end else begin
          a_d = a_q + 1'b1;
        end
      end
      S_SPAN0: begin
        b_d = IdxW'(CntW'(a_q) + t_q);
        dim_raddr = a_q;
        state_d = S_SPAN1;
      end
      S_SPAN1: begin
        pa_d = dim_rdata;
        dim_raddr = b_q;
        state_d = S_SPAN2;
      end
      S_SPAN2: begin
        pb_d = dim_rdata;
        k_d = a_q + 1'b1;
        state_d = S_K0;
      end
      S_K0: begin
        dim_raddr = k_q;
        cost_raddr = tab_addr(a_q, k_q);
        state_d = S_K1;
      end
      S_K1: begin
        pk_d = dim_rdata;
        c1_d = cost_rdata;
        cost_raddr = tab_addr(k_q, b_q);
        state_d = S_K2;
      end
      S_K2: begin
        p1_d = ProdW'(pa_q) * ProdW'(pk_q);
        wide_sum = {1'b0, c1_q} + {1'b0, cost_rdata};
        sum_d = wide_sum[CostW] ? CostMax : wide_sum[CostW-1:0];
        state_d = S_K3;
      end
      S_K3: begin
        // At most 3*DIM_BITS bits, so the product never saturates.
        p2_d = CostW'(p1_q) * CostW'(pb_q);
        state_d = S_K4;
      end
      S_K4: begin
        wide_sum = {1'b0, p2_q} + {1'b0, sum_q};
        cand = wide_sum[CostW] ? CostMax : wide_sum[CostW-1:0];
        // Strict compare keeps the lowest split on ties.
        if (k_q == a_q + 1'b1 || cand < best_q) begin
          best_d = cand;
          bestk_d = k_q;
        end
        if (k_q + 1'b1 == b_q) begin
          state_d = S_WR;
        end else begin
          k_d = k_q + 1'b1;
          state_d = S_K0;
        end
      end
      S_WR: begin
        cost_we = 1'b1;
        if ((CntW + 1)'(a_q) + (CntW + 1)'(t_q) + 1'b1 <= (CntW + 1)'(n_q)) begin
          a_d = a_q + 1'b1;
          state_d = S_SPAN0;
        end else begin
          a_d = '0;
          t_d = t_q + 1'b1;
          state_d = (t_q + 1'b1 > CntW'(n_q)) ? S_TOT0 : S_SPAN0;
        end
      end
      S_TOT0: begin
        cost_raddr = tab_addr('0, n_q);
        state_d = S_TOT1;
      end
      S_TOT1: begin
        rv_d = 1'b1;
        rkind_d = KindCost;
        rcost_d = (n_q >= IdxW'(1)) ? cost_rdata : '0;
        rs_d = '0;
        re_d = '0;
        rk_d = '0;
        rovf_d = ovf_q;
        if (n_q >= IdxW'(2)) begin
          rlast_d = 1'b0;
          stack_d[0] = '{lo: '0, hi: n_q};
          sp_d = CntW'(1);
          state_d = S_POP;
        end else begin
          rlast_d = 1'b1;
          cnt_d = '0;
          ovf_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_POP: begin
        sp_pop = sp_q - 1'b1;
        top = stack_q[sp_pop[IdxW-1:0]];
        a_d = top.lo;
        b_d = top.hi;
        sp_d = sp_pop;
        cost_raddr = tab_addr(top.lo, top.hi);
        state_d = S_EMIT;
      end
      S_EMIT: begin
        push_r = (b_q > split_rdata + 1'b1) && (sp_q < CntW'(NDims));
        sp_pop = sp_q + CntW'(push_r);
        push_l = (split_rdata > a_q + 1'b1) && (sp_pop < CntW'(NDims));
        if (push_r) begin
          stack_d[sp_q[IdxW-1:0]] = '{lo: split_rdata, hi: b_q};
        end
        if (push_l) begin
          stack_d[sp_pop[IdxW-1:0]] = '{lo: a_q, hi: split_rdata};
        end
        sp_d = sp_pop + CntW'(push_l);
        rv_d = 1'b1;
        rkind_d = KindSplit;
        rcost_d = '0;
        rs_d = a_q;
        re_d = b_q;
        rk_d = split_rdata;
        rovf_d = ovf_q;
        rlast_d = (sp_d == '0);
        if (sp_d == '0) begin
          cnt_d = '0;
          ovf_d = 1'b0;
          state_d = S_IDLE;
        end else begin
          state_d = S_POP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      sp_q  <= '0;
      rv_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      sp_q  <= sp_d;
      rv_q  <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;       t_q <= t_d;
    a_q <= a_d;       b_q <= b_d;       k_q <= k_d;
    pa_q <= pa_d;     pb_q <= pb_d;     pk_q <= pk_d;
    c1_q <= c1_d;     sum_q <= sum_d;   p1_q <= p1_d;  p2_q <= p2_d;
    best_q <= best_d; bestk_q <= bestk_d;
    stack_q <= stack_d;
    rkind_q <= rkind_d; rcost_q <= rcost_d;
    rs_q <= rs_d;     re_q <= re_d;     rk_q <= rk_d;
    rlast_q <= rlast_d; rovf_q <= rovf_d;
  end

  assign result_valid_o = rv_q;
  assign result_kind_o  = rkind_q;
  assign total_cost_o   = rcost_q;
  assign span_start_o   = SpanW'(rs_q);
  assign span_end_o     = SpanW'(re_q);
  assign split_at_o     = SpanW'(rk_q);
  assign overflow_o     = rovf_q;
  assign last_result_o  = rlast_q;

  // A split result always lies strictly inside its span.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q && rkind_q == KindSplit |-> rs_q < rk_q && rk_q < re_q)
    else $error("split point outside its span");

  // The final result of a chain returns the block to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q && rlast_q |-> state_q == S_IDLE && cnt_q == '0)
    else $error("chain not closed after its final result");

  // Results appear only out of the traceback states.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> $past(state_q) == S_TOT1 || $past(state_q) == S_EMIT)
    else $error("result strobe outside the traceback");

  // The trace stack never holds more spans than there are dimensions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= CntW'(NDims))
    else $error("trace stack overrun");

endmodule
